/* hdl/ps2m_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ps2m_pkg
// Shared types and constants for the ps/2 mouse packet decoder.
// ----------------------------------------------------------------------------
package ps2m_pkg;

    localparam int unsigned CoordW   = 12;
    localparam int unsigned DeltaW   = 9;
    localparam int unsigned ButtonW  = 3;
    localparam int unsigned InDataW  = 32;
    localparam int unsigned OutDataW = 48;
    localparam int unsigned CfgIdxW  = 1;

    // register indexes of the configuration port
    localparam logic [CfgIdxW-1:0] CFG_MAX_X = 1'b0;
    localparam logic [CfgIdxW-1:0] CFG_MAX_Y = 1'b1;

    // input kinds carried in tuser
    localparam logic ACT_RX_BYTE = 1'b0;
    localparam logic ACT_SET_POS = 1'b1;

    // first byte bit positions
    localparam int unsigned SYNC_BIT   = 3;
    localparam int unsigned X_SIGN_BIT = 4;
    localparam int unsigned Y_SIGN_BIT = 5;

    // bytes dropped while waiting for a packet start
    localparam logic [7:0] BYTE_ACK    = 8'hFA;
    localparam logic [7:0] BYTE_RESEND = 8'hFE;
    localparam logic [7:0] BYTE_ERROR  = 8'hFF;

    localparam logic [CoordW-1:0] MAX_X_RESET    = 12'd799;
    localparam logic [CoordW-1:0] MAX_Y_RESET    = 12'd599;
    localparam logic [CoordW-1:0] CURSOR_X_RESET = 12'd400;
    localparam logic [CoordW-1:0] CURSOR_Y_RESET = 12'd300;

    typedef enum logic [1:0] {
        PKT_WAIT_FIRST  = 2'd0,
        PKT_WAIT_SECOND = 2'd1,
        PKT_WAIT_THIRD  = 2'd2
    } t_pkt_state;

    typedef struct packed {
        logic [ButtonW-1:0]       buttons;
        logic signed [DeltaW-1:0] delta_y;
        logic signed [DeltaW-1:0] delta_x;
        logic [CoordW-1:0]        pos_y;
        logic [CoordW-1:0]        pos_x;
    } t_result;

    // clamp a signed position into 0..limit
    function automatic logic [CoordW-1:0] clamp_pos(
        input logic signed [CoordW+1:0] v,
        input logic [CoordW-1:0]        limit
    );
        logic [CoordW-1:0] res;
        if (v[CoordW+1]) begin
            res = '0;
        end else if (v[CoordW:0] > {1'b0, limit}) begin
            res = limit;
        end else begin
            res = v[CoordW-1:0];
        end
        return res;
    endfunction

endpackage : ps2m_pkg
`default_nettype wire

/* hdl/ps2_mouse_packet_decoder.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ps2_mouse_packet_decoder
// Assembles ps/2 mouse bytes into three-byte packets and tracks a cursor.
//
// Input stream: s_axis_tuser selects the kind (0 = mouse byte, 1 = set
// cursor position), s_axis_tdata carries the byte and the new position.
// Every mouse byte that completes a packet gives one transaction on the
// output stream with the clamped cursor, the deltas and the buttons; other
// bytes and set-position items give none.
// Each result is registered (output register, or skid register on stall).
// One item is taken every cycle while s_axis_tready is high: the cursor
// and packet state update in the accepting cycle, so a dependent item may
// follow directly. Results sit in an output register backed by one skid
// register; while the receiver stalls, input keeps flowing until the skid
// register is also full, then s_axis_tready drops until the receiver takes a result.
// Reset puts max_x/max_y to 799/599, the cursor to 400/300, empties both
// result registers and waits for a packet start byte.
// The configuration port writes max_x (index 0) or max_y (index 1).
// ----------------------------------------------------------------------------
module ps2_mouse_packet_decoder (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    // slave stream
    input  wire logic                             s_axis_tvalid,
    output logic                                  s_axis_tready,
    // rx_byte[7:0], set_x[19:8], set_y[31:20]
    input  wire logic [ps2m_pkg::InDataW-1:0]     s_axis_tdata,
    // action[0]
    input  wire logic                             s_axis_tuser,
    // master stream
    output logic                                  m_axis_tvalid,
    input  wire logic                             m_axis_tready,
    // pos_x[11:0], pos_y[23:12], delta_x[32:24], delta_y[41:33],
    // buttons[44:42], zero[47:45]
    output logic [ps2m_pkg::OutDataW-1:0]         m_axis_tdata,
    // configuration
    input  wire logic                             i_cfg_we,
    input  wire logic [ps2m_pkg::CfgIdxW-1:0]     i_cfg_idx,
    input  wire logic [ps2m_pkg::CoordW-1:0]      i_cfg_data
);
    import ps2m_pkg::*;

    t_pkt_state r_state, n_state;
    logic [7:0]        r_first, n_first;
    logic [7:0]        r_second, n_second;
    logic [CoordW-1:0] r_cursor_x, n_cursor_x;
    logic [CoordW-1:0] r_cursor_y, n_cursor_y;
    logic [CoordW-1:0] r_max_x, r_max_y;

    t_result r_out, r_skid;
    logic    r_out_valid, r_skid_valid;

    logic              in_accept;
    logic              in_action;
    logic [7:0]        in_byte;
    logic [CoordW-1:0] in_set_x, in_set_y;
    logic              res_valid;
    t_result           res;

    logic signed [DeltaW-1:0]   dx, dy;
    logic signed [CoordW+1:0]   sum_x, sum_y;

    assign in_action = s_axis_tuser;
    assign in_byte   = s_axis_tdata[7:0];
    assign in_set_x  = s_axis_tdata[19:8];
    assign in_set_y  = s_axis_tdata[31:20];

    assign s_axis_tready = !r_skid_valid;
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    assign dx    = {r_first[X_SIGN_BIT], r_second};
    assign dy    = {r_first[Y_SIGN_BIT], in_byte};
    assign sum_x = $signed({2'b00, r_cursor_x}) + (CoordW+2)'(dx);
    assign sum_y = $signed({2'b00, r_cursor_y}) - (CoordW+2)'(dy);

    // packet assembly and cursor update
    always_comb begin
        n_state    = r_state;
        n_first    = r_first;
        n_second   = r_second;
        n_cursor_x = r_cursor_x;
        n_cursor_y = r_cursor_y;
        res_valid  = 1'b0;
        res        = '{buttons: r_first[ButtonW-1:0], delta_y: dy, delta_x: dx,
                       pos_y: clamp_pos(sum_y, r_max_y),
                       pos_x: clamp_pos(sum_x, r_max_x)};
        if (in_accept) begin
            if (in_action == ACT_SET_POS) begin
                n_cursor_x = in_set_x;
                n_cursor_y = in_set_y;
            end else begin
                unique case (r_state)
                    PKT_WAIT_SECOND: begin
                        n_second = in_byte;
                        n_state  = PKT_WAIT_THIRD;
                    end
                    PKT_WAIT_THIRD: begin
                        n_state    = PKT_WAIT_FIRST;
                        n_cursor_x = res.pos_x;
                        n_cursor_y = res.pos_y;
                        res_valid  = 1'b1;
                    end
                    default: begin
                        if (in_byte != BYTE_ACK && in_byte != BYTE_RESEND &&
                            in_byte != BYTE_ERROR && in_byte[SYNC_BIT]) begin
                            n_first = in_byte;
                            n_state = PKT_WAIT_SECOND;
                        end
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= PKT_WAIT_FIRST;
            r_first    <= '0;
            r_second   <= '0;
            r_cursor_x <= CURSOR_X_RESET;
            r_cursor_y <= CURSOR_Y_RESET;
        end else begin
            r_state    <= n_state;
            r_first    <= n_first;
            r_second   <= n_second;
            r_cursor_x <= n_cursor_x;
            r_cursor_y <= n_cursor_y;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_x <= MAX_X_RESET;
            r_max_y <= MAX_Y_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_MAX_X: r_max_x <= i_cfg_data;
                CFG_MAX_Y: r_max_y <= i_cfg_data;
                default:   ;
            endcase
        end
    end

    // output register with skid register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (r_skid_valid) begin
                if (m_axis_tready) begin
                    r_skid_valid <= 1'b0;
                end
            end else if (res_valid) begin
                if (r_out_valid && !m_axis_tready) begin
                    r_skid_valid <= 1'b1;
                end else begin
                    r_out_valid <= 1'b1;
                end
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (m_axis_tready) begin
                r_out <= r_skid;
            end
        end else if (res_valid) begin
            if (r_out_valid && !m_axis_tready) begin
                r_skid <= res;
            end else begin
                r_out <= res;
            end
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {(OutDataW - $bits(t_result))'(0), r_out};

    // checks
    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid register holds a result while output register is empty");

    a_packet_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && in_action == ACT_RX_BYTE && r_state == PKT_WAIT_THIRD)
        |=> (m_axis_tvalid && r_state == PKT_WAIT_FIRST))
        else $error("completed packet produced no result");

    a_cursor_clamped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && in_action == ACT_RX_BYTE && r_state == PKT_WAIT_THIRD && !i_cfg_we)
        |=> (r_cursor_x <= r_max_x && r_cursor_y <= r_max_y))
        else $error("cursor outside limits after packet");

    a_set_keeps_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && in_action == ACT_SET_POS) |=> (r_state == $past(r_state)))
        else $error("set position changed packet position");

endmodule : ps2_mouse_packet_decoder
`default_nettype wire

/* bench/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stream-level test of the ps/2 mouse packet decoder. A hand-written table
// covers dropped bytes, sign and clamp extremes and set-position items. It is
// followed by random packets mixed with noise bytes and cursor loads. These
// run under several max_x/max_y settings and with random gaps on the input
// stream and random stalls on the output stream. Every output transaction is
// checked field by field against a cycle-free packet and cursor tracker.
// ----------------------------------------------------------------------------
module tb_top;
    import ps2m_pkg::*;

    typedef struct {
        logic              act;
        logic [7:0]        rx;
        logic [CoordW-1:0] sx;
        logic [CoordW-1:0] sy;
        bit                typed;
        t_result           move;
    } t_stim_row;

    logic                i_clk;
    logic                i_rst_n       = 1'b0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    // rx_byte[7:0], set_x[19:8], set_y[31:20]
    logic [InDataW-1:0]  s_axis_tdata  = '0;
    // action[0]
    logic                s_axis_tuser  = ACT_RX_BYTE;
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    // pos_x[11:0], pos_y[23:12], delta_x[32:24], delta_y[41:33], buttons[44:42]
    logic [OutDataW-1:0] m_axis_tdata;
    logic                i_cfg_we      = 1'b0;
    logic [CfgIdxW-1:0]  i_cfg_idx     = CFG_MAX_X;
    logic [CoordW-1:0]   i_cfg_data    = '0;

    // tracker state
    t_pkt_state        pkt_pos;
    logic [7:0]        hdr_byte;
    logic [7:0]        x_low;
    logic [CoordW-1:0] cur_x;
    logic [CoordW-1:0] cur_y;
    logic [CoordW-1:0] lim_x;
    logic [CoordW-1:0] lim_y;

    t_result     pending_moves[$];
    t_stim_row   stim_rows[$];
    int unsigned src_idle_pct;
    int unsigned sink_stall_pct;
    int          mismatch_count;
    t_result     seen_move;
    t_result     want_move;

    ps2_mouse_packet_decoder u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #3_000_000;
        $display("status: fail");
        $finish;
    end

    // packet assembly and cursor update for one accepted transaction
    task automatic decode_mouse_item(input logic act, input logic [InDataW-1:0] data,
                                     output bit made, output t_result mv);
        logic [7:0] rx;
        int         dx;
        int         dy;
        int         nx;
        int         ny;
        rx   = data[7:0];
        made = 1'b0;
        mv   = '0;
        if (act == ACT_SET_POS) begin
            cur_x = data[19:8];
            cur_y = data[31:20];
        end else begin
            case (pkt_pos)
                PKT_WAIT_SECOND: begin
                    x_low   = rx;
                    pkt_pos = PKT_WAIT_THIRD;
                end
                PKT_WAIT_THIRD: begin
                    dx = hdr_byte[X_SIGN_BIT] ? int'(x_low) - 256 : int'(x_low);
                    dy = hdr_byte[Y_SIGN_BIT] ? int'(rx) - 256 : int'(rx);
                    nx = int'(cur_x) + dx;
                    ny = int'(cur_y) - dy;
                    if (nx < 0) cur_x = '0;
                    else if (nx > int'(lim_x)) cur_x = lim_x;
                    else cur_x = nx[CoordW-1:0];
                    if (ny < 0) cur_y = '0;
                    else if (ny > int'(lim_y)) cur_y = lim_y;
                    else cur_y = ny[CoordW-1:0];
                    mv.pos_x   = cur_x;
                    mv.pos_y   = cur_y;
                    mv.delta_x = dx[DeltaW-1:0];
                    mv.delta_y = dy[DeltaW-1:0];
                    mv.buttons = hdr_byte[ButtonW-1:0];
                    made       = 1'b1;
                    pkt_pos    = PKT_WAIT_FIRST;
                end
                default: begin
                    if (rx != BYTE_ACK && rx != BYTE_RESEND && rx != BYTE_ERROR
                        && rx[SYNC_BIT]) begin
                        hdr_byte = rx;
                        pkt_pos  = PKT_WAIT_SECOND;
                    end
                end
            endcase
        end
    endtask

    task automatic apply_item(input logic act, input logic [7:0] rx,
                              input logic [CoordW-1:0] sx, input logic [CoordW-1:0] sy,
                              input bit typed, input t_result typed_mv);
        bit      made;
        t_result mv;
        while ($urandom_range(99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= act;
        s_axis_tdata  <= {sy, sx, rx};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        decode_mouse_item(act, {sy, sx, rx}, made, mv);
        if (typed) pending_moves.push_back(typed_mv);
        else if (made) pending_moves.push_back(mv);
    endtask

    task automatic rand_byte(input logic [7:0] rx);
        apply_item(ACT_RX_BYTE, rx, CoordW'($urandom), CoordW'($urandom), 1'b0, '0);
    endtask

    task automatic rand_pos();
        logic [CoordW-1:0] x;
        logic [CoordW-1:0] y;
        x = $urandom_range(1) ? CoordW'($urandom_range(4095)) : CoordW'($urandom_range(lim_x));
        y = $urandom_range(1) ? CoordW'($urandom_range(4095)) : CoordW'($urandom_range(lim_y));
        apply_item(ACT_SET_POS, 8'($urandom_range(255)), x, y, 1'b0, '0);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (pending_moves.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_limits(input logic [CoordW-1:0] mx, input logic [CoordW-1:0] my);
        wait_drained();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_MAX_X;
        i_cfg_data <= mx;
        @(posedge i_clk);
        i_cfg_idx  <= CFG_MAX_Y;
        i_cfg_data <= my;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        lim_x = mx;
        lim_y = my;
    endtask

    task automatic add_row(input logic act, input logic [7:0] rx,
                           input logic [CoordW-1:0] sx, input logic [CoordW-1:0] sy,
                           input bit typed, input int px, input int py,
                           input int dx, input int dy, input int btn);
        t_stim_row r;
        r.act          = act;
        r.rx           = rx;
        r.sx           = sx;
        r.sy           = sy;
        r.typed        = typed;
        r.move.pos_x   = px[CoordW-1:0];
        r.move.pos_y   = py[CoordW-1:0];
        r.move.delta_x = dx[DeltaW-1:0];
        r.move.delta_y = dy[DeltaW-1:0];
        r.move.buttons = btn[ButtonW-1:0];
        stim_rows.push_back(r);
    endtask

    task automatic run_random(input int unsigned count);
        int unsigned done;
        int unsigned roll;
        done = 0;
        while (done < count) begin
            roll = $urandom_range(99);
            if (roll < 6) begin
                rand_pos();
                done++;
            end else if (roll < 16) begin
                rand_byte(8'($urandom_range(255)));
                done++;
            end else begin
                rand_byte(8'($urandom_range(255)) | 8'h08);
                rand_byte(8'($urandom_range(255)));
                if (roll < 20) begin
                    rand_pos();
                    done++;
                end
                rand_byte(8'($urandom_range(255)));
                done += 3;
            end
        end
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            seen_move = t_result'(m_axis_tdata[$bits(t_result)-1:0]);
            if (pending_moves.size() == 0) begin
                $error("result transaction with none expected: %h", m_axis_tdata);
                mismatch_count++;
            end else begin
                want_move = pending_moves.pop_front();
                check_field("pos_x", int'(want_move.pos_x), int'(seen_move.pos_x));
                check_field("pos_y", int'(want_move.pos_y), int'(seen_move.pos_y));
                check_field("delta_x", int'(want_move.delta_x), int'(seen_move.delta_x));
                check_field("delta_y", int'(want_move.delta_y), int'(seen_move.delta_y));
                check_field("buttons", int'(want_move.buttons), int'(seen_move.buttons));
            end
        end
    end

    initial begin
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        mismatch_count = 0;
        pkt_pos        = PKT_WAIT_FIRST;
        hdr_byte       = '0;
        x_low          = '0;
        cur_x          = CURSOR_X_RESET;
        cur_y          = CURSOR_Y_RESET;
        lim_x          = MAX_X_RESET;
        lim_y          = MAX_Y_RESET;

        // no sync bit, then ack / resend / error while waiting for a start
        add_row(ACT_RX_BYTE, 8'h00, 0, 0, 0, 0, 0, 0, 0, 0);
        add_row(ACT_RX_BYTE, BYTE_ACK, 0, 0, 0, 0, 0, 0, 0, 0);
        add_row(ACT_RX_BYTE, BYTE_RESEND, 0, 0, 0, 0, 0, 0, 0, 0);
        add_row(ACT_RX_BYTE, BYTE_ERROR, 0, 0, 0, 0, 0, 0, 0, 0);
        // all buttons, no motion, from the reset cursor
        add_row(ACT_RX_BYTE, 8'h0F, 0, 0, 0, 0, 0, 0, 0, 0);
        add_row(ACT_RX_BYTE, 8'h00, 0, 0, 0, 0, 0, 0, 0, 0);
        add_row(ACT_RX_BYTE, 8'h00, 0, 0, 1, 400, 300, 0, 0, 7);
        // resend and error bytes as data, both signs set
        add_row(ACT_RX_BYTE, 8'h38, 0, 0, 0, 0, 0, 0, 0, 0);
        add_row(ACT_RX_BYTE, BYTE_ERROR, 0, 0, 0, 0, 0, 0, 0, 0);
        add_row(ACT_RX_BYTE, BYTE_RESEND, 0, 0, 1, 399, 302, -1, -2, 0);
        // dx = -256, dy = +255
        add_row(ACT_RX_BYTE, 8'h19, 0, 0, 0, 0, 0, 0, 0, 0);
        add_row(ACT_RX_BYTE, 8'h00, 0, 0, 0, 0, 0, 0, 0, 0);
        add_row(ACT_RX_BYTE, 8'hFF, 0, 0, 1, 143, 47, -256, 255, 1);
        // dx = +255, dy = -256
        add_row(ACT_RX_BYTE, 8'h2A, 0, 0, 0, 0, 0, 0, 0, 0);
        add_row(ACT_RX_BYTE, 8'hFF, 0, 0, 0, 0, 0, 0, 0, 0);
        add_row(ACT_RX_BYTE, 8'h00, 0, 0, 1, 398, 303, 255, -256, 2);
        // cursor loaded above max, clamped by the next packet
        add_row(ACT_SET_POS, 8'h00, 4095, 4095, 0, 0, 0, 0, 0, 0);
        add_row(ACT_RX_BYTE, 8'h08, 0, 0, 0, 0, 0, 0, 0, 0);
        add_row(ACT_RX_BYTE, 8'h00, 0, 0, 0, 0, 0, 0, 0, 0);
        add_row(ACT_RX_BYTE, 8'h00, 0, 0, 1, 799, 599, 0, 0, 0);
        // clamp below zero on both axes
        add_row(ACT_SET_POS, 8'h00, 0, 0, 0, 0, 0, 0, 0, 0);
        add_row(ACT_RX_BYTE, 8'h18, 0, 0, 0, 0, 0, 0, 0, 0);
        add_row(ACT_RX_BYTE, 8'h00, 0, 0, 0, 0, 0, 0, 0, 0);
        add_row(ACT_RX_BYTE, 8'h01, 0, 0, 1, 0, 0, -256, 1, 0);
        // set position mid-packet keeps the packet position, ack byte as data
        add_row(ACT_RX_BYTE, 8'h0C, 0, 0, 0, 0, 0, 0, 0, 0);
        add_row(ACT_SET_POS, 8'h00, 100, 200, 0, 0, 0, 0, 0, 0);
        add_row(ACT_RX_BYTE, 8'h02, 0, 0, 0, 0, 0, 0, 0, 0);
        add_row(ACT_RX_BYTE, BYTE_ACK, 0, 0, 1, 102, 0, 2, 250, 4);

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (stim_rows[i]) begin
            apply_item(stim_rows[i].act, stim_rows[i].rx, stim_rows[i].sx,
                       stim_rows[i].sy, stim_rows[i].typed, stim_rows[i].move);
        end

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin
                    write_limits(12'd4095, 12'd4095);
                    src_idle_pct   = 0;
                    sink_stall_pct = 0;
                end
                1: begin
                    write_limits(12'd0, 12'd0);
                    src_idle_pct   = 74;
                    sink_stall_pct = 0;
                end
                2: begin
                    write_limits(CoordW'($urandom_range(4095)), CoordW'($urandom_range(4095)));
                    src_idle_pct   = 0;
                    sink_stall_pct = 74;
                end
                default: begin
                    write_limits(CoordW'($urandom_range(60)), CoordW'($urandom_range(60)));
                    src_idle_pct   = 17;
                    sink_stall_pct = 17;
                end
            endcase
            run_random(250);
        end

        wait_drained();
        if (mismatch_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule : tb_top
